[hw/rtl/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types and codes for the stack calculator
// ----------------------------------------------------------------------------
package rpn_pkg;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_SQRT  = 3'd5,
    OP_POW   = 3'd6,
    OP_CLEAR = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_OVF     = 3'd2,
    ST_DIV0    = 3'd3,
    ST_NEGROOT = 3'd4,
    ST_FRAC    = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic [4:0]         depth;
  } out_item_t;

  // stack cell control: hold, push (shift down from above), pop (shift up),
  // replace top, pop and replace new top
  typedef enum logic [2:0] {
    SC_HOLD  = 3'd0,
    SC_PUSH  = 3'd1,
    SC_POP   = 3'd2,
    SC_SET   = 3'd3,
    SC_POPSET = 3'd4
  } stk_cmd_e;

  typedef struct packed {
    stk_cmd_e           cmd;
    logic signed [31:0] data;
  } stk_ctl_t;

endpackage

[hw/rtl/rpn_cell.sv]
// ----------------------------------------------------------------------------
// rpn_cell
// one stack slot; slot 0 is the top, data moves one slot per cycle
// ----------------------------------------------------------------------------
module rpn_cell (
  input  logic                   clk_i,
  input  rpn_pkg::stk_ctl_t      ctl_i,
  input  logic                   is_top_i,
  input  logic                   is_second_i,
  input  logic signed [31:0]     above_i,
  input  logic signed [31:0]     below_i,
  output logic signed [31:0]     q_o
);
  import rpn_pkg::*;

  logic signed [31:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.cmd)
      SC_PUSH:   val_d = is_top_i ? ctl_i.data : above_i;
      SC_POP:    val_d = below_i;
      SC_SET:    if (is_top_i) begin
                   val_d = ctl_i.data;
                 end
      SC_POPSET: val_d = is_top_i ? ctl_i.data : below_i;
      default:   val_d = val_q;
    endcase
  end

  // is_second_i is unused by the value path; it only forces the register enable
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd != SC_HOLD || is_second_i) begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;
endmodule

[hw/rtl/rpn_alu.sv]
// ----------------------------------------------------------------------------
// rpn_alu
// multi-cycle fixed-point unit: add, sub, mul, div, sqrt, pow
// ----------------------------------------------------------------------------
module rpn_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rpn_pkg::op_e       op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);
  import rpn_pkg::*;

  localparam int unsigned DW = 32 + FRAC_BITS;   // dividend width

  typedef enum logic [3:0] {
    A_IDLE, A_MUL1, A_MUL2, A_DIV, A_DIVF, A_SQRT, A_PSTEP,
    A_PMUL1, A_PMUL2, A_PINV, A_DONE
  } alu_e;

  alu_e state_q;
  logic signed [31:0] res_q;

  // shared multiplier operands and product
  logic signed [31:0] ma_q, mb_q;
  logic [63:0]        prod_q;
  logic               mneg_q;

  // divider
  logic [DW-1:0]      dq_q;      // dividend shifting into quotient
  logic [32:0]        drem_q;
  logic [31:0]        dden_q;
  logic [6:0]         dcnt_q;
  logic               dneg_q;

  // sqrt (bit-pair restoring)
  logic [63:0]        sx_q;
  logic [31:0]        sr_q;
  logic [33:0]        srem_q;
  logic [5:0]         scnt_q;

  // pow
  logic [31:0]        pe_q;      // exponent magnitude
  logic               pinv_q;
  logic signed [31:0] pr_q, pbase_q;
  logic               psel_q;    // 0: r*base, 1: base*base

  logic [31:0] mag_a, mag_b;
  assign mag_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign mag_b = b_i[31] ? 32'(-b_i) : 32'(b_i);

  // unsigned operand magnitudes for the multiplier
  logic [31:0] mul_ma, mul_mb;
  assign mul_ma = ma_q[31] ? 32'(-ma_q) : 32'(ma_q);
  assign mul_mb = mb_q[31] ? 32'(-mb_q) : 32'(mb_q);

  function automatic logic signed [31:0] from_mag(input logic [63:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (m >= 64'h8000_0000) r = 32'sh8000_0000;
      else r = 32'(-$signed(m));
    end else begin
      if (m > 64'h7fff_ffff) r = 32'sh7fff_ffff;
      else r = 32'(m);
    end
    return r;
  endfunction

  // product scaled back to fixed point, rounding toward minus infinity
  logic [63:0] mul_sh;
  logic signed [31:0] mul_res;
  always_comb begin
    if (mneg_q) mul_sh = (prod_q + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS;
    else        mul_sh = prod_q >> FRAC_BITS;
    mul_res = from_mag(mul_sh, mneg_q);
  end

  // divider step
  logic [32:0] dtrial;
  logic [32:0] drem_sh;
  assign drem_sh = {drem_q[31:0], dq_q[DW-1]};
  assign dtrial  = drem_sh - {1'b0, dden_q};

  // sqrt step
  logic [33:0] s_in, s_trial;
  assign s_in    = {srem_q[31:0], sx_q[63:62]};
  assign s_trial = s_in - {sr_q, 2'b01};

  logic signed [31:0] sum_ext;
  logic signed [32:0] addsub;
  assign addsub = (op_i == OP_ADD) ? (33'(a_i) + 33'(b_i)) : (33'(a_i) - 33'(b_i));
  assign sum_ext = (addsub > 33'sd2147483647) ? 32'sh7fff_ffff :
                   (addsub < -33'sd2147483648) ? 32'sh8000_0000 : 32'(addsub);

  logic signed [31:0] pn;
  assign pn = b_i >>> FRAC_BITS;   // b integer, exact since fraction is zero

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      unique case (state_q)
        A_IDLE: if (start_i) begin
          unique case (op_i)
            OP_ADD, OP_SUB: begin
              res_q <= sum_ext;
              state_q <= A_DONE;
            end
            OP_MUL: begin
              ma_q <= a_i; mb_q <= b_i;
              state_q <= A_MUL1;
            end
            OP_DIV: begin
              dq_q   <= DW'(mag_a) << FRAC_BITS;
              drem_q <= '0;
              dden_q <= mag_b;
              dcnt_q <= 7'(DW);
              dneg_q <= a_i[31] ^ b_i[31];
              state_q <= A_DIV;
            end
            OP_SQRT: begin
              sx_q   <= 64'(mag_b) << FRAC_BITS;
              sr_q   <= '0;
              srem_q <= '0;
              scnt_q <= 6'd32;
              state_q <= A_SQRT;
            end
            OP_POW: begin
              pe_q    <= pn[31] ? 32'(-pn) : 32'(pn);
              pinv_q  <= pn[31];
              pr_q    <= 32'sd1 <<< FRAC_BITS;
              pbase_q <= a_i;
              state_q <= A_PSTEP;
            end
            default: state_q <= A_DONE;
          endcase
        end
        A_MUL1: begin
          prod_q <= 64'(mul_ma) * 64'(mul_mb);
          mneg_q <= ma_q[31] ^ mb_q[31];
          state_q <= A_MUL2;
        end
        A_MUL2: begin
          res_q <= mul_res;
          state_q <= A_DONE;
        end
        A_DIV: begin
          dq_q <= {dq_q[DW-2:0], ~dtrial[32]};
          drem_q <= dtrial[32] ? drem_sh : dtrial;
          dcnt_q <= dcnt_q - 7'd1;
          if (dcnt_q == 7'd1) state_q <= A_DIVF;
        end
        A_DIVF: begin
          res_q <= from_mag(64'(dq_q), dneg_q);
          state_q <= A_DONE;
        end
        A_SQRT: begin
          sx_q <= sx_q << 2;
          if (!s_trial[33]) begin
            srem_q <= s_trial;
            sr_q   <= {sr_q[30:0], 1'b1};
          end else begin
            srem_q <= s_in;
            sr_q   <= {sr_q[30:0], 1'b0};
          end
          scnt_q <= scnt_q - 6'd1;
          if (scnt_q == 6'd1) state_q <= A_PMUL2;  // reuse finish below
        end
        A_PSTEP: begin
          if (pe_q == '0) begin
            state_q <= pinv_q ? A_PINV : A_DONE;
            res_q <= pr_q;
          end else if (pe_q[0]) begin
            ma_q <= pr_q; mb_q <= pbase_q; psel_q <= 1'b0;
            state_q <= A_PMUL1;
          end else begin
            ma_q <= pbase_q; mb_q <= pbase_q; psel_q <= 1'b1;
            state_q <= A_PMUL1;
          end
        end
        A_PMUL1: begin
          prod_q <= 64'(mul_ma) * 64'(mul_mb);
          mneg_q <= ma_q[31] ^ mb_q[31];
          state_q <= A_PMUL2;
        end
        A_PMUL2: begin
          if (op_i == OP_SQRT) begin
            res_q <= $signed(sr_q);
            state_q <= A_DONE;
          end else if (!psel_q) begin
            pr_q <= mul_res;
            // square the base only when higher bits remain
            if (pe_q[31:1] != '0) begin
              pe_q[0] <= 1'b0;
              ma_q <= pbase_q; mb_q <= pbase_q; psel_q <= 1'b1;
              state_q <= A_PMUL1;
            end else begin
              pe_q <= '0;
              state_q <= A_PSTEP;
            end
          end else begin
            pbase_q <= mul_res;
            pe_q <= pe_q >> 1;
            state_q <= A_PSTEP;
          end
        end
        A_PINV: begin
          if (pr_q == '0) begin
            res_q <= 32'sh7fff_ffff;
            state_q <= A_DONE;
          end else begin
            dq_q   <= DW'(32'd1 << FRAC_BITS) << FRAC_BITS;
            drem_q <= '0;
            dden_q <= pr_q[31] ? 32'(-pr_q) : 32'(pr_q);
            dcnt_q <= 7'(DW);
            dneg_q <= pr_q[31];
            state_q <= A_DIV;
          end
        end
        A_DONE: state_q <= A_IDLE;
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == A_DONE);
  assign res_o  = res_q;
endmodule

[hw/rtl/rpn_stack_calculator_unit.sv]
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit
// reverse polish calculator on signed fixed-point values, stack as cell chain
// ----------------------------------------------------------------------------
// usage:
//  - input channel in_valid_i/in_ready_o carries one item: an operation code
//    and a value that is pushed when the operation is push
//  - output channel out_valid_o/out_ready_i returns one item per input item:
//    status, new top value (zero when empty) and new depth
//  - one item is worked on at a time; push, clear and error cases do not use
//    the alu, add/sub need no iteration, mul uses the multiplier, div takes
//    one quotient bit a cycle over 32+FRAC_BITS bits, sqrt one root bit a
//    cycle, and pow runs up to two multiplies per exponent bit plus a divide
//    for a negative exponent; all of these share one alu
//  - the stack lives in a row of cells, slot 0 on top; push shifts every
//    slot down and pop shifts every slot up, all slots together
//  - a finished item sits in the output register; a new item is taken once
//    the output register is free, so a stalled receiver stalls the block
//  - reset empties the stack (depth zero); slot contents are not cleared
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rpn_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rpn_pkg::out_item_t   out_item_o
);
  import rpn_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_ALU, S_UPD, S_OUT} state_e;

  state_e           state_q;
  logic [CW-1:0]    cnt_q;
  op_e              op_q;
  logic [2:0]       stat_q;
  stk_ctl_t         ctl;
  logic             alu_start;
  logic             alu_done;
  logic signed [31:0] alu_res;
  out_item_t        out_q;
  logic             out_valid_q;

  // cell chain
  logic signed [31:0] cell_q [STACK_DEPTH];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    rpn_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .is_top_i    (g == 0),
      .is_second_i (1'b0),
      .above_i     (g == 0 ? ctl.data : cell_q[(g == 0) ? 0 : g - 1]),
      .below_i     (cell_q[(g == STACK_DEPTH - 1) ? g : g + 1]),
      .q_o         (cell_q[g])
    );
  end

  logic signed [31:0] top_b, sec_a;
  assign top_b = cell_q[0];
  assign sec_a = cell_q[1];

  rpn_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (op_q),
    .a_i     (sec_a),
    .b_i     (top_b),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  logic in_fire;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // decode of the accepted op against the current depth
  logic [2:0]  dec_stat;
  logic        dec_alu;
  stk_cmd_e    dec_cmd;
  logic [CW-1:0] dec_cnt;
  op_e         in_op;
  assign in_op = op_e'(in_item_i.op);

  always_comb begin
    dec_stat = ST_OK;
    dec_alu  = 1'b0;
    dec_cmd  = SC_HOLD;
    dec_cnt  = cnt_q;
    unique case (in_op)
      OP_PUSH: begin
        if (cnt_q >= CW'(STACK_DEPTH)) dec_stat = ST_OVF;
        else begin
          dec_cmd = SC_PUSH;
          dec_cnt = cnt_q + 1'b1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_POW: begin
        if (cnt_q < CW'(2)) dec_stat = ST_FEW;
        else if (in_op == OP_POW && (32'(top_b) & ((32'd1 << FRAC_BITS) - 32'd1)) != '0)
          dec_stat = ST_FRAC;
        else dec_alu = 1'b1;
      end
      OP_DIV: begin
        if (cnt_q < CW'(2)) dec_stat = ST_FEW;
        else if (top_b == '0) begin
          dec_stat = ST_DIV0;
          dec_cmd  = SC_POP;
          dec_cnt  = cnt_q - 1'b1;
        end else dec_alu = 1'b1;
      end
      OP_SQRT: begin
        if (cnt_q == '0) dec_stat = ST_FEW;
        else if (top_b[31]) begin
          dec_stat = ST_NEGROOT;
          dec_cmd  = SC_POP;
          dec_cnt  = cnt_q - 1'b1;
        end else dec_alu = 1'b1;
      end
      default: dec_cnt = '0;
    endcase
  end

  // stack command this cycle
  always_comb begin
    ctl.cmd  = SC_HOLD;
    ctl.data = '0;
    alu_start = 1'b0;
    if (state_q == S_ALU) begin
      alu_start = 1'b1;
    end
    if (state_q == S_UPD) begin
      ctl.cmd = stk_cmd_e'(SC_HOLD);
    end
    if (in_fire) begin
      ctl.data = in_item_i.value;
      ctl.cmd  = dec_alu ? SC_HOLD : dec_cmd;
    end else if (state_q == S_ALU && alu_done) begin
      ctl.data = alu_res;
      ctl.cmd  = (op_q == OP_SQRT) ? SC_SET : SC_POPSET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          op_q   <= in_op;
          stat_q <= dec_stat;
          cnt_q  <= dec_cnt;
          state_q <= dec_alu ? S_ALU : S_UPD;
        end
        S_ALU: if (alu_done) begin
          if (op_q != OP_SQRT) cnt_q <= cnt_q - 1'b1;
          state_q <= S_UPD;
        end
        S_UPD: begin
          out_q.status    <= stat_q;
          out_q.top_value <= (cnt_q == '0) ? 32'sd0 : cell_q[0];
          out_q.depth     <= 5'(cnt_q);
          out_valid_q     <= 1'b1;
          state_q         <= S_OUT;
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

[hw/rtl/rpn_checker.sv]
// ----------------------------------------------------------------------------
// rpn_checker
// port-level checks on the stack calculator
// ----------------------------------------------------------------------------
module rpn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rpn_pkg::out_item_t out_item_o
);
  import rpn_pkg::*;

  // output holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // no new item taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while output pending");

  // one item at a time: ready drops right after an accepted item
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // empty stack shows zero on top
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.depth == 5'd0 |-> out_item_o.top_value == 32'sd0)
    else $error("nonzero top on empty stack");

  // status within its codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status <= 3'd5)
    else $error("status code out of range");
endmodule

bind rpn_stack_calculator_unit rpn_checker u_rpn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[sim/rpn_stack_calculator_checker.sv]
// ----------------------------------------------------------------------------
// rpn_stack_calculator_checker
// watches both channels, predicts each result item from the accepted
// operations with its own stack copy, and compares field by field
// ----------------------------------------------------------------------------
module rpn_stack_calculator_checker
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_cnt_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_Q = 32'sh80000000;

  logic signed [31:0] calc_stack [STACK_DEPTH];
  int unsigned        calc_depth;
  out_item_t          expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic signed [31:0] from_mag(logic [63:0] m, bit neg);
    if (neg) begin
      if (m >= 64'h80000000) return MIN_Q;
      return -$signed(m[31:0]);
    end
    if (m > 64'h7fffffff) return MAX_Q;
    return m[31:0];
  endfunction

  function automatic logic [63:0] mag_of(logic signed [31:0] a);
    logic signed [63:0] w;
    w = a;
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic signed [31:0] sat_wide(logic signed [63:0] v);
    if (v > 64'sh7fffffff) return MAX_Q;
    if (v < -64'sh80000000) return MIN_Q;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic [63:0] p;
    bit neg;
    p = mag_of(a) * mag_of(b);
    neg = (a < 0) != (b < 0);
    if (neg) return from_mag((p + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS, 1'b1);
    return from_mag(p >> FRAC_BITS, 1'b0);
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [31:0] a,
                                                logic signed [31:0] b);
    return from_mag((mag_of(a) << FRAC_BITS) / mag_of(b), (a < 0) != (b < 0));
  endfunction

  // bitwise integer root of a shifted up by the fraction width
  function automatic logic signed [31:0] fx_sqrt(logic signed [31:0] a);
    logic [63:0] x, r, bt;
    x = {32'd0, a} << FRAC_BITS;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] fx_pow(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [31:0] one, r, base;
    logic signed [63:0] n;
    logic [63:0] e;
    one = 32'sd1 <<< FRAC_BITS;
    n = 64'(b) / (64'sd1 <<< FRAC_BITS);  // truncates toward zero
    e = (n < 0) ? -n : n;
    r = one;
    base = a;
    while (e != 0) begin
      if (e[0]) r = fx_mul(r, base);
      e >>= 1;
      if (e != 0) base = fx_mul(base, base);
    end
    if (n < 0) begin
      if (r == 0) return MAX_Q;
      return fx_div(one, r);
    end
    return r;
  endfunction

  function automatic out_item_t apply_op(in_item_t it);
    out_item_t res;
    status_e st;
    logic signed [31:0] a, b;
    int unsigned n;
    st = ST_OK;
    n = calc_depth;
    a = 0;
    b = 0;
    if (n >= 1) b = calc_stack[n-1];
    if (n >= 2) a = calc_stack[n-2];
    case (op_e'(it.op))
      OP_PUSH: begin
        if (n >= STACK_DEPTH) st = ST_OVF;
        else begin
          calc_stack[n] = it.value;
          calc_depth = n + 1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_POW: begin
        if (n < 2) st = ST_FEW;
        else if (op_e'(it.op) == OP_POW && (b & ((32'sd1 <<< FRAC_BITS) - 1)) != 0)
          st = ST_FRAC;
        else begin
          case (op_e'(it.op))
            OP_ADD:  a = sat_wide(64'(a) + 64'(b));
            OP_SUB:  a = sat_wide(64'(a) - 64'(b));
            OP_MUL:  a = fx_mul(a, b);
            default: a = fx_pow(a, b);
          endcase
          calc_stack[n-2] = a;
          calc_depth = n - 1;
        end
      end
      OP_DIV: begin
        if (n < 2) st = ST_FEW;
        else if (b == 0) begin
          st = ST_DIV0;
          calc_depth = n - 1;
        end else begin
          calc_stack[n-2] = fx_div(a, b);
          calc_depth = n - 1;
        end
      end
      OP_SQRT: begin
        if (n < 1) st = ST_FEW;
        else if (b < 0) begin
          st = ST_NEGROOT;
          calc_depth = n - 1;
        end else calc_stack[n-1] = fx_sqrt(b);
      end
      default: calc_depth = 0;
    endcase
    res.status = st;
    res.top_value = calc_depth ? calc_stack[calc_depth-1] : 32'sd0;
    res.depth = calc_depth[4:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      calc_depth = 0;
      fail_cnt_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(apply_op(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: %p", out_item_i);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_item_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_i.status);
            errs++;
          end
          if (out_item_i.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value,
                   out_item_i.top_value);
            errs++;
          end
          if (out_item_i.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, out_item_i.depth);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
    end
  end

endmodule

[sim/rpn_stack_calculator_unit_tb.sv]
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit_tb
// drives directed and random operation streams with random gaps on both
// sides; the checker predicts and compares, this top gives the verdict
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_tb;
  import rpn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned FRAC  = 16;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        fail_cnt;
  int        pending;
  bit        stim_done = 1'b0;

  always #1 clk = ~clk;

  rpn_stack_calculator_unit #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  rpn_stack_calculator_checker #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // pick a gap length; some stretches run with no gaps at all
  function automatic int draw_gap(bit busy_phase);
    if (busy_phase) return 0;
    return $urandom_range(0, 19);
  endfunction

  // one operation: optional gap, then hold valid until accepted
  task automatic send_op(op_e op, logic signed [31:0] val, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.op <= op;
    in_item.value <= val;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random value mix: small integers, fractions, extremes, raw bits
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 20) - 10) <<< FRAC;
      1: return $signed($urandom_range(0, 2 * ONE) - ONE);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return 32'sd0;
      4: return $signed($urandom_range(0, 6) - 3) <<< FRAC;  // exponents
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic op_e rand_op(int unsigned depth_est);
    int unsigned r;
    r = $urandom_range(0, 99);
    // favor pushes while shallow so binary operations see operands
    if (depth_est < 2 && r < 60) return OP_PUSH;
    if (r < 35) return OP_PUSH;
    if (r < 45) return OP_ADD;
    if (r < 55) return OP_SUB;
    if (r < 65) return OP_MUL;
    if (r < 75) return OP_DIV;
    if (r < 83) return OP_SQRT;
    if (r < 95) return OP_POW;
    return OP_CLEAR;
  endfunction

  // receiver side: random stalls, with quiet stretches
  initial begin
    int stall;
    bit quiet;
    @(posedge rst_n);
    forever begin
      quiet = ($urandom_range(0, 7) == 0);
      repeat ($urandom_range(5, 40)) begin
        stall = draw_gap(quiet);
        @(negedge clk);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned depth_est;
    op_e op;
    bit quiet;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-stack errors, extremes, each operation and error case
    send_op(OP_ADD, 0, 0);                  // too few operands
    send_op(OP_SQRT, 0, 1);
    send_op(OP_PUSH, 32'sh7fffffff, 0);
    send_op(OP_PUSH, 32'sh7fffffff, 0);
    send_op(OP_ADD, 0, 2);                  // positive saturation
    send_op(OP_PUSH, 32'sh80000000, 0);
    send_op(OP_MUL, 0, 0);                  // negative saturation
    send_op(OP_PUSH, 0, 0);
    send_op(OP_DIV, 0, 0);                  // zero divisor pops it
    send_op(OP_PUSH, -ONE, 0);
    send_op(OP_SQRT, 0, 0);                 // negative root pops it
    send_op(OP_PUSH, ONE + 1, 0);
    send_op(OP_POW, 0, 0);                  // fractional exponent
    send_op(OP_CLEAR, 0, 3);
    send_op(OP_PUSH, 2 * ONE, 0);
    send_op(OP_PUSH, -3 * ONE, 0);
    send_op(OP_POW, 0, 0);                  // negative exponent
    send_op(OP_PUSH, 0, 0);
    send_op(OP_PUSH, -2 * ONE, 0);
    send_op(OP_POW, 0, 0);                  // zero power with negative exponent
    send_op(OP_PUSH, 9 * ONE, 0);
    send_op(OP_SQRT, 0, 0);
    send_op(OP_SUB, 0, 0);
    for (int i = 0; i < DEPTH + 1; i++) send_op(OP_PUSH, $signed($urandom()), 0);
    send_op(OP_CLEAR, 0, 0);                // overflow above, then empty

    // random part
    depth_est = 0;
    quiet = 1'b0;
    for (int i = 0; i < 1000; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 4) == 0);
      op = rand_op(depth_est);
      send_op(op, rand_value(), draw_gap(quiet));
      case (op)
        OP_PUSH:  if (depth_est < DEPTH) depth_est++;
        OP_CLEAR: depth_est = 0;
        OP_SQRT:  ;
        default:  if (depth_est >= 2) depth_est--;
      endcase
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
